// File: rtl/swmq_pkg.sv
// Shared types, constants and helper functions of the stack with median query.
`timescale 1ns / 1ps

package swmq_pkg;

  // Stored values and the count tree span 2**VALUE_BITS positions.
  localparam int VALUE_BITS  = 16;
  localparam int STACK_DEPTH = 1024;

  localparam int STACK_AW   = $clog2(STACK_DEPTH);
  localparam int COUNT_BITS = $clog2(STACK_DEPTH + 1);

  // Stream field widths, fixed by the item format.
  localparam int OPCODE_W     = 2;
  localparam int VALUE_W      = 16;
  localparam int STATUS_W     = 2;
  localparam int IN_PAYLOAD_W  = OPCODE_W + VALUE_W;
  localparam int OUT_PAYLOAD_W = STATUS_W + VALUE_W;
  localparam int IN_TDATA_W    = ((IN_PAYLOAD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W   = ((OUT_PAYLOAD_W + 7) / 8) * 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    TREE_INC,
    TREE_DEC,
    TREE_SELECT
  } tree_op_e;

  typedef enum logic [1:0] {
    T_CLEAR,
    T_IDLE,
    T_UPDATE,
    T_SELECT
  } tree_state_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_RD,
    S_SELECT
  } ctrl_state_e;

  typedef struct packed {
    logic                  valid;
    tree_op_e              op;
    logic [VALUE_BITS-1:0] key;
    logic [COUNT_BITS-1:0] target;
  } tree_req_t;

  typedef struct packed {
    logic                  ready;
    logic                  done;
    logic [VALUE_BITS-1:0] key;
  } tree_rsp_t;

  // Field value to tree key: bits at and above VALUE_BITS are dropped.
  function automatic logic [VALUE_BITS-1:0] to_key(logic [VALUE_W-1:0] v);
    logic [VALUE_BITS-1:0] k;
    k = '0;
    for (int i = 0; i < VALUE_BITS; i++) begin
      if (i < VALUE_W) begin
        k[i] = v[i];
      end
    end
    return k;
  endfunction

  // Tree key back to the result field width.
  function automatic logic [VALUE_W-1:0] from_key(logic [VALUE_BITS-1:0] k);
    logic [VALUE_W-1:0] v;
    v = '0;
    for (int i = 0; i < VALUE_W; i++) begin
      if (i < VALUE_BITS) begin
        v[i] = k[i];
      end
    end
    return v;
  endfunction

endpackage

// File: rtl/swmq_tree.sv
// Fenwick count tree in one synchronous memory with update and select walks.
`timescale 1ns / 1ps

module swmq_tree (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  swmq_pkg::tree_req_t req_i,
  output swmq_pkg::tree_rsp_t rsp_o
);
  import swmq_pkg::*;

  localparam int TREE_ENTRIES = 1 << VALUE_BITS;
  localparam logic [VALUE_BITS-1:0] TOP_STEP = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // Entry i holds tree position i; position 0 is never used and the root
  // (position 2**VALUE_BITS) is never needed, since it always equals the size.
  logic [COUNT_BITS-1:0] mem [TREE_ENTRIES];
  logic [COUNT_BITS-1:0] rdata_q;

  tree_state_e           state_q, state_d;
  logic [VALUE_BITS-1:0] pos_q, pos_d;
  logic [VALUE_BITS-1:0] step_q, step_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic                  dec_q, dec_d;
  logic [VALUE_BITS-1:0] clr_q, clr_d;

  logic                  we;
  logic [VALUE_BITS-1:0] waddr;
  logic [COUNT_BITS-1:0] wdata;
  logic [VALUE_BITS-1:0] raddr;

  logic [VALUE_BITS:0]   start_pos;
  logic [VALUE_BITS-1:0] low_bit;
  logic [VALUE_BITS:0]   upd_next;
  logic                  sel_hit;
  logic [VALUE_BITS-1:0] sel_pos;
  logic [VALUE_BITS-1:0] step_next;

  assign start_pos = {1'b0, req_i.key} + {{VALUE_BITS{1'b0}}, 1'b1};
  assign low_bit   = pos_q & (~pos_q + {{(VALUE_BITS-1){1'b0}}, 1'b1});
  assign upd_next  = {1'b0, pos_q} + {1'b0, low_bit};
  assign sel_hit   = rdata_q < rem_q;
  assign sel_pos   = sel_hit ? (pos_q | step_q) : pos_q;
  assign step_next = step_q >> 1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      T_CLEAR: begin
        if (&clr_q) begin
          state_d = T_IDLE;
        end
      end
      T_IDLE: begin
        if (req_i.valid) begin
          if (req_i.op == TREE_SELECT) begin
            state_d = T_SELECT;
          end else if (!start_pos[VALUE_BITS]) begin
            state_d = T_UPDATE;
          end
        end
      end
      T_UPDATE: begin
        if (upd_next[VALUE_BITS]) begin
          state_d = T_IDLE;
        end
      end
      T_SELECT: begin
        if (step_q[0]) begin
          state_d = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_comb begin
    we     = 1'b0;
    waddr  = pos_q;
    wdata  = rdata_q;
    raddr  = pos_q;
    pos_d  = pos_q;
    step_d = step_q;
    rem_d  = rem_q;
    dec_d  = dec_q;
    clr_d  = clr_q;
    rsp_o.ready = 1'b0;
    rsp_o.done  = 1'b0;
    rsp_o.key   = sel_pos;
    case (state_q)
      T_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + {{(VALUE_BITS-1){1'b0}}, 1'b1};
      end
      T_IDLE: begin
        rsp_o.ready = 1'b1;
        if (req_i.valid) begin
          if (req_i.op == TREE_SELECT) begin
            pos_d  = '0;
            step_d = TOP_STEP;
            rem_d  = req_i.target;
            raddr  = TOP_STEP;
          end else begin
            pos_d = start_pos[VALUE_BITS-1:0];
            dec_d = (req_i.op == TREE_DEC);
            raddr = start_pos[VALUE_BITS-1:0];
          end
        end
      end
      T_UPDATE: begin
        // Write back this position while the next one up is being read.
        we    = 1'b1;
        wdata = dec_q ? rdata_q - {{(COUNT_BITS-1){1'b0}}, 1'b1}
                      : rdata_q + {{(COUNT_BITS-1){1'b0}}, 1'b1};
        pos_d = upd_next[VALUE_BITS-1:0];
        raddr = upd_next[VALUE_BITS-1:0];
      end
      T_SELECT: begin
        pos_d  = sel_pos;
        rem_d  = sel_hit ? rem_q - rdata_q : rem_q;
        step_d = step_next;
        raddr  = sel_pos | step_next;
        rsp_o.done = step_q[0];
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    step_q <= step_d;
    rem_q  <= rem_d;
    dec_q  <= dec_d;
  end

`ifndef ASSERT_OFF
  a_req_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid |-> state_q == T_IDLE)
    else $error("tree request while the tree is busy");

  a_select_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == T_SELECT |-> rem_q != '0)
    else $error("select walk lost its remaining rank");

  a_done_in_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |-> state_q == T_SELECT)
    else $error("select done outside a select walk");
`endif

endmodule

// File: rtl/stack_with_median_query_core.sv
// Top level: stack memory, control sequencer and result registers.
// A push with room gives no result and keeps the block busy while the count tree is updated.
// A pop result passes the stack read, the pending and the output register; a peek result waits
// for the select walk. With a free output the next item is taken once the tree walk of a pop or
// peek is done; the walk reads, and in an update writes, one tree entry per cycle in one memory.
// After reset the count tree is cleared entry by entry; no item is accepted until it is done.
`timescale 1ns / 1ps

module stack_with_median_query_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [1:0] opcode, [17:2] value, rest zero
  input  logic [swmq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [1:0] status, [17:2] result_value, rest zero
  output logic [swmq_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import swmq_pkg::*;

  logic [VALUE_BITS-1:0] stack_mem [STACK_DEPTH];
  logic [VALUE_BITS-1:0] stack_rdata_q;
  logic                  stack_we;
  logic [STACK_AW-1:0]   stack_waddr;
  logic [STACK_AW-1:0]   stack_raddr;

  ctrl_state_e           state_q, state_d;
  logic [COUNT_BITS-1:0] count_q, count_d;

  logic                  pend_valid_q, pend_valid_d;
  status_e               pend_status_q, pend_status_d;
  logic [VALUE_W-1:0]    pend_value_q, pend_value_d;
  logic                  out_valid_q;
  status_e               out_status_q;
  logic [VALUE_W-1:0]    out_value_q;
  logic                  out_load;

  tree_req_t             tree_req;
  tree_rsp_t             tree_rsp;

  opcode_e               in_opcode;
  logic [VALUE_BITS-1:0] in_key;
  logic                  in_accept;
  logic                  stack_full;
  logic                  stack_empty;
  logic [COUNT_BITS:0]   count_inc;
  logic [COUNT_BITS-1:0] count_dec;

  assign in_opcode   = opcode_e'(s_axis_tdata[OPCODE_W-1:0]);
  assign in_key      = to_key(s_axis_tdata[IN_PAYLOAD_W-1:OPCODE_W]);
  assign in_accept   = s_axis_tvalid && s_axis_tready;
  assign stack_full  = (count_q == COUNT_BITS'(STACK_DEPTH));
  assign stack_empty = (count_q == '0);
  assign count_inc   = {1'b0, count_q} + {{COUNT_BITS{1'b0}}, 1'b1};
  assign count_dec   = count_q - {{(COUNT_BITS-1){1'b0}}, 1'b1};

  swmq_tree u_tree (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tree_req),
    .rsp_o  (tree_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept && !stack_empty) begin
          case (in_opcode)
            OP_PUSH: state_d = S_IDLE;
            OP_POP:  state_d = S_POP_RD;
            default: state_d = S_SELECT;
          endcase
        end
      end
      S_POP_RD: state_d = S_IDLE;
      S_SELECT: begin
        if (tree_rsp.done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready   = 1'b0;
    stack_we        = 1'b0;
    stack_waddr     = count_q[STACK_AW-1:0];
    stack_raddr     = count_dec[STACK_AW-1:0];
    count_d         = count_q;
    pend_valid_d    = pend_valid_q;
    pend_status_d   = pend_status_q;
    pend_value_d    = pend_value_q;
    tree_req.valid  = 1'b0;
    tree_req.op     = TREE_INC;
    tree_req.key    = in_key;
    tree_req.target = count_inc[COUNT_BITS:1];
    out_load        = pend_valid_q && (!out_valid_q || m_axis_tready);
    if (out_load) begin
      pend_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        s_axis_tready = tree_rsp.ready && !pend_valid_q;
        if (in_accept) begin
          case (in_opcode)
            OP_PUSH: begin
              if (stack_full) begin
                pend_valid_d  = 1'b1;
                pend_status_d = ST_FULL;
                pend_value_d  = '0;
              end else begin
                stack_we       = 1'b1;
                count_d        = count_inc[COUNT_BITS-1:0];
                tree_req.valid = 1'b1;
              end
            end
            default: begin
              if (stack_empty) begin
                pend_valid_d  = 1'b1;
                pend_status_d = ST_EMPTY;
                pend_value_d  = '0;
              end else if (in_opcode == OP_POP) begin
                count_d = count_dec;
              end else begin
                // Median rank is (size+1)/2, which picks the lower median.
                tree_req.valid = 1'b1;
                tree_req.op    = TREE_SELECT;
              end
            end
          endcase
        end
      end
      S_POP_RD: begin
        pend_valid_d   = 1'b1;
        pend_status_d  = ST_OK;
        pend_value_d   = from_key(stack_rdata_q);
        tree_req.valid = 1'b1;
        tree_req.op    = TREE_DEC;
        tree_req.key   = stack_rdata_q;
      end
      S_SELECT: begin
        if (tree_rsp.done) begin
          pend_valid_d  = 1'b1;
          pend_status_d = ST_OK;
          pend_value_d  = from_key(tree_rsp.key);
        end
      end
      default: begin
        pend_valid_d = pend_valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= in_key;
    end
    stack_rdata_q <= stack_mem[stack_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      pend_valid_q <= pend_valid_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_status_q <= pend_status_d;
    pend_value_q  <= pend_value_d;
    if (out_load) begin
      out_status_q <= pend_status_q;
      out_value_q  <= pend_value_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_PAYLOAD_W){1'b0}}, out_value_q, out_status_q};

`ifndef ASSERT_OFF
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_BITS'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_ready_needs_tree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> tree_rsp.ready && !pend_valid_q)
    else $error("item taken while tree busy or result pending");

  a_pop_reads_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP_RD |-> count_q + 1'b1 == $past(count_q))
    else $error("pop read without a count decrement");
`endif

endmodule

// File: verif/tb_stack_with_median_query_core.sv
// Self-checking testbench of the stack with median query core.
`timescale 1ns / 1ps

module tb_stack_with_median_query_core;
  import swmq_pkg::*;

  localparam int          TREE_SPAN   = 1 << VALUE_BITS;
  localparam logic [1:0]  OP_PEEK_ALT = 2'd3;  // Unused code, taken as a peek.
  localparam int          HOLD_AT     = 40;
  localparam int          HOLD_CYCLES = 600;
  localparam int          DRAIN_WAIT  = 40;
  localparam int          CYCLE_LIMIT = 1_000_000;

  typedef struct {
    logic [OPCODE_W-1:0] opcode;
    logic [VALUE_W-1:0]  value;
  } stack_cmd_t;

  typedef struct {
    status_e            status;
    logic [VALUE_W-1:0] value;
  } stack_reply_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  stack_with_median_query_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Mirror of the block state.
  logic [VALUE_W-1:0]    shadow_stack [0:STACK_DEPTH-1];
  logic [COUNT_BITS-1:0] shadow_depth = '0;
  bit   [COUNT_BITS-1:0] shadow_counts [1:TREE_SPAN];

  stack_cmd_t   pending_cmds [$];
  stack_reply_t expected_replies [$];

  int mismatches = 0;
  int gen_depth = 0;
  int cmds_sent = 0;
  int gap_cycles = 0;
  bit tx_burst = 1'b0;
  int replies_taken = 0;
  int stall_cycles = 0;
  bit rx_burst = 1'b0;
  int cycle_count = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic note_mismatch(input string what, input logic [1:0] exp_status,
                               input logic [VALUE_W-1:0] exp_value,
                               input logic [1:0] act_status,
                               input logic [VALUE_W-1:0] act_value);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected status %0d value %0d, got status %0d value %0d",
               $realtime, what, exp_status, exp_value, act_status, act_value);
    end
  endtask

  function automatic void count_tree_add(input logic [VALUE_W-1:0] v, input bit inc);
    int pos;
    pos = int'(v[VALUE_BITS-1:0]) + 1;
    while (pos <= TREE_SPAN) begin
      if (inc) begin
        shadow_counts[pos] = shadow_counts[pos] + 1'b1;
      end else begin
        shadow_counts[pos] = shadow_counts[pos] - 1'b1;
      end
      pos += pos & (-pos);
    end
  endfunction

  // Fenwick descent: smallest value whose running count reaches rank.
  function automatic logic [VALUE_W-1:0] median_lookup(input int rank);
    int pos;
    int remaining;
    int step;
    int probe;
    pos = 0;
    remaining = rank;
    step = TREE_SPAN;
    while (step != 0) begin
      probe = pos + step;
      if (probe <= TREE_SPAN && int'(shadow_counts[probe]) < remaining) begin
        pos = probe;
        remaining -= int'(shadow_counts[probe]);
      end
      step >>= 1;
    end
    return pos[VALUE_W-1:0];
  endfunction

  function automatic void apply_stack_cmd(input stack_cmd_t cmd);
    stack_reply_t reply;
    reply.status = ST_OK;
    reply.value = '0;
    if (cmd.opcode == OP_PUSH) begin
      if (shadow_depth >= STACK_DEPTH) begin
        reply.status = ST_FULL;
        expected_replies.push_back(reply);
      end else begin
        shadow_stack[shadow_depth[STACK_AW-1:0]] = cmd.value;
        shadow_depth = shadow_depth + 1'b1;
        count_tree_add(cmd.value, 1'b1);
      end
    end else if (shadow_depth == 0) begin
      reply.status = ST_EMPTY;
      expected_replies.push_back(reply);
    end else if (cmd.opcode == OP_POP) begin
      shadow_depth = shadow_depth - 1'b1;
      reply.value = shadow_stack[shadow_depth[STACK_AW-1:0]];
      count_tree_add(reply.value, 1'b0);
      expected_replies.push_back(reply);
    end else begin
      reply.value = median_lookup((int'(shadow_depth) + 1) / 2);
      expected_replies.push_back(reply);
    end
  endfunction

  // Stimulus side keeps its own depth count to know when the stack is full.
  task automatic queue_cmd(input logic [1:0] opcode, input logic [VALUE_W-1:0] value);
    stack_cmd_t cmd;
    cmd.opcode = opcode;
    cmd.value = value;
    pending_cmds.push_back(cmd);
    if (opcode == OP_PUSH) begin
      if (gen_depth < STACK_DEPTH) gen_depth++;
    end else if (opcode == OP_POP && gen_depth > 0) begin
      gen_depth--;
    end
  endtask

  // Mostly a few repeating values so that medians land on duplicates.
  function automatic logic [VALUE_W-1:0] draw_value();
    case ($urandom_range(0, 3))
      0, 1: return VALUE_W'($urandom_range(0, 15));
      2: return VALUE_W'($urandom_range(65520, 65535));
      default: return VALUE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [1:0] draw_opcode(input int push_pct, input int pop_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) return OP_PUSH;
    if (roll < push_pct + pop_pct) return OP_POP;
    if (roll < 95) return OP_PEEK;
    return OP_PEEK_ALT;
  endfunction

  // Driver.
  always @(posedge clk_i) begin
    logic                  next_valid;
    logic [IN_TDATA_W-1:0] next_data;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      next_valid = s_axis_tvalid;
      next_data = s_axis_tdata;
      if (s_axis_tvalid && s_axis_tready) begin
        apply_stack_cmd(pending_cmds.pop_front());
        cmds_sent++;
        if (cmds_sent % 50 == 0) tx_burst = ($urandom_range(0, 3) == 0);
        gap_cycles = tx_burst ? 0 : $urandom_range(0, 19);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_cycles > 0) begin
          gap_cycles--;
        end else if (pending_cmds.size() != 0) begin
          next_valid = 1'b1;
          next_data = '0;
          next_data[OPCODE_W-1:0] = pending_cmds[0].opcode;
          next_data[OPCODE_W +: VALUE_W] = pending_cmds[0].value;
        end
      end
      s_axis_tvalid <= next_valid;
      s_axis_tdata <= next_data;
    end
  end

  // Receiver ready, with one long hold-off so the block backs up into its input.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        replies_taken++;
        if (replies_taken == HOLD_AT) begin
          stall_cycles = HOLD_CYCLES;
        end else begin
          stall_cycles = rx_burst ? 0 : $urandom_range(0, 19);
        end
        if (replies_taken % 32 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      end
      if (stall_cycles > 0) begin
        stall_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    stack_reply_t       want;
    logic [1:0]         got_status;
    logic [VALUE_W-1:0] got_value;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_status = m_axis_tdata[STATUS_W-1:0];
      got_value = m_axis_tdata[STATUS_W +: VALUE_W];
      if (expected_replies.size() == 0) begin
        note_mismatch("unexpected item", 2'd0, '0, got_status, got_value);
      end else begin
        want = expected_replies.pop_front();
        if (got_status != want.status || got_value != want.value) begin
          note_mismatch("wrong item", want.status, want.value, got_status, got_value);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    stack_reply_t left;
    // Empty stack and the unused opcode.
    queue_cmd(OP_POP, 16'hFFFF);
    queue_cmd(OP_PEEK, 16'h0000);
    queue_cmd(OP_PEEK_ALT, 16'h1234);
    // Value extremes and lower median on an even count.
    queue_cmd(OP_PUSH, 16'h0000);
    queue_cmd(OP_PEEK, 16'hFFFF);
    queue_cmd(OP_PUSH, 16'hFFFF);
    queue_cmd(OP_PEEK, 16'h0000);
    queue_cmd(OP_PEEK_ALT, 16'h0000);
    queue_cmd(OP_PUSH, 16'hFFFF);
    queue_cmd(OP_PEEK, 16'h5555);
    queue_cmd(OP_POP, 16'hAAAA);
    queue_cmd(OP_POP, 16'h0000);
    queue_cmd(OP_POP, 16'h0000);
    queue_cmd(OP_POP, 16'h0000);
    queue_cmd(OP_PUSH, 16'h5555);
    queue_cmd(OP_PUSH, 16'hAAAA);
    queue_cmd(OP_PUSH, 16'h0001);
    queue_cmd(OP_PEEK, 16'hFFFF);
    queue_cmd(OP_POP, 16'hFFFF);
    queue_cmd(OP_PEEK_ALT, 16'hFFFF);
    queue_cmd(OP_POP, 16'h0000);
    queue_cmd(OP_POP, 16'h0000);
    queue_cmd(OP_PEEK, 16'h0000);

    // Mixed traffic that lets the stack grow slowly.
    repeat (450) queue_cmd(draw_opcode(45, 25), draw_value());
    // Fill to the top, then push against a full stack.
    while (gen_depth < STACK_DEPTH) begin
      if ($urandom_range(0, 9) == 0) queue_cmd(OP_PEEK, draw_value());
      else queue_cmd(OP_PUSH, draw_value());
    end
    repeat (4) queue_cmd(OP_PUSH, draw_value());
    queue_cmd(OP_PEEK, draw_value());
    queue_cmd(OP_POP, draw_value());
    queue_cmd(OP_PUSH, draw_value());
    queue_cmd(OP_PUSH, draw_value());
    queue_cmd(OP_PEEK_ALT, draw_value());
    // Draining traffic.
    repeat (150) queue_cmd(draw_opcode(10, 60), draw_value());

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || s_axis_tvalid || expected_replies.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_WAIT) @(posedge clk_i);
    while (expected_replies.size() != 0) begin
      left = expected_replies.pop_front();
      note_mismatch("missing item", left.status, left.value, 2'd0, '0);
    end

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/swmq_pkg.sv
rtl/swmq_tree.sv
rtl/stack_with_median_query_core.sv
verif/tb_stack_with_median_query_core.sv
